>>> rtl/hsvrgb_pkg.sv
`default_nettype none

package hsvrgb_pkg;

  // Field widths of the color items.
  localparam int HueW  = 13;
  localparam int FracW = 9;
  localparam int ChanW = 8;

  // Hue is in 1/16 degree: one full turn and one 60-degree sector.
  localparam logic [HueW-1:0]  HueTurn   = HueW'(5760);
  localparam logic [HueW-1:0]  HueSector = HueW'(960);
  localparam logic [FracW-1:0] FracOne   = FracW'(256);

  // Offset of the hue within a sector (0..959) and the weight of x (0..960).
  localparam int FracHueW = 10;

  // Product v*s (0..65536) and the scaled channel numerators (0..65536*960).
  localparam int VsW  = 17;
  localparam int NumW = 26;

  // Intermediate channel value floor(numer*255 / 2^22), 0..3825.
  localparam int PreW = 12;

  // Sixty-degree hue sectors, named after the colors they span.
  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_t;

endpackage

`default_nettype wire

>>> rtl/hsv_in_if.sv
`default_nettype none

interface hsv_in_if
  import hsvrgb_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [HueW-1:0]  hue;
  logic [FracW-1:0] saturation;
  logic [FracW-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/rgb_out_if.sv
`default_nettype none

interface rgb_out_if
  import hsvrgb_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

>>> rtl/hsv_to_rgb_converter.sv
`default_nettype none

// Channel   Dir  Handshake     Payload
// in_chan   in   valid/ready   hue[12:0], saturation[8:0], brightness[8:0]
// out_chan  out  valid/ready   red[7:0], green[7:0], blue[7:0]
//
// Five register stages; one item is accepted per clock while the output is
// not stalled. An item taken into stage 1 passes through stages 2, 3 and 4
// to the stage 5 output register, from which it is taken. The pipeline
// advances as a whole whenever the output register is empty or its
// item is being taken. Reset (synchronous, active low) clears only the valid
// bits. A stall at the output freezes every stage; nothing is lost.

module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  hsv_in_if.sink    in_chan,
  rgb_out_if.source out_chan
);

  // Sector boundaries in hue units.
  localparam logic [HueW-1:0] Bound1 = HueW'(960);
  localparam logic [HueW-1:0] Bound2 = HueW'(1920);
  localparam logic [HueW-1:0] Bound3 = HueW'(2880);
  localparam logic [HueW-1:0] Bound4 = HueW'(3840);
  localparam logic [HueW-1:0] Bound5 = HueW'(4800);

  // floor(p/15) for p < 2^16 equals (p*Recip15) >> Recip15Shift.
  localparam logic [15:0] Recip15      = 16'd34953;
  localparam int          Recip15Shift = 19;
  localparam int          QuoW         = PreW + 16 - Recip15Shift;

  // Scale a 0..65536*960 numerator to 0..3825: floor(numer*255 / 2^22).
  function automatic logic [PreW-1:0] scale_255(input logic [NumW-1:0] numer);
    logic [NumW+7:0] prod;
    prod      = (NumW+8)'(numer) * (NumW+8)'(255);
    scale_255 = prod[NumW+7:NumW+8-PreW];
  endfunction

  // Finish the division by 65536*960: divide by 15 and clamp to 8 bits.
  function automatic logic [ChanW-1:0] div15_clamp(input logic [PreW-1:0] p);
    logic [PreW+15:0] prod;
    logic [QuoW-1:0]  quo;
    prod = (PreW+16)'(p) * (PreW+16)'(Recip15);
    quo  = prod[PreW+15:Recip15Shift];
    if (quo > QuoW'(255)) begin
      div15_clamp = '1;
    end else begin
      div15_clamp = quo[ChanW-1:0];
    end
  endfunction

  logic advance;

  // The whole pipeline moves when the output register can take an item.
  assign advance       = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = advance;

  // ---------------------------------------------------------------- stage 1
  logic                s1_valid_r;
  sector_t             s1_sec_r, s1_sec_nxt;
  logic [FracHueW-1:0] s1_frac_r, s1_frac_nxt;
  logic [FracW-1:0]    s1_sat_r, s1_sat_nxt;
  logic [FracW-1:0]    s1_val_r, s1_val_nxt;
  logic [HueW-1:0]     hue_wrap;
  logic [HueW-1:0]     hue_base;

  // Wrap the hue into one turn, find its sector and the offset inside it.
  always_comb begin
    hue_wrap = (in_chan.hue >= HueTurn) ? in_chan.hue - HueTurn : in_chan.hue;
    if (hue_wrap < Bound1) begin
      s1_sec_nxt = SEC_R_Y;
      hue_base   = '0;
    end else if (hue_wrap < Bound2) begin
      s1_sec_nxt = SEC_Y_G;
      hue_base   = Bound1;
    end else if (hue_wrap < Bound3) begin
      s1_sec_nxt = SEC_G_C;
      hue_base   = Bound2;
    end else if (hue_wrap < Bound4) begin
      s1_sec_nxt = SEC_C_B;
      hue_base   = Bound3;
    end else if (hue_wrap < Bound5) begin
      s1_sec_nxt = SEC_B_M;
      hue_base   = Bound4;
    end else begin
      s1_sec_nxt = SEC_M_R;
      hue_base   = Bound5;
    end
    s1_frac_nxt = FracHueW'(hue_wrap - hue_base);
    s1_sat_nxt  = (in_chan.saturation > FracOne) ? FracOne : in_chan.saturation;
    s1_val_nxt  = (in_chan.brightness > FracOne) ? FracOne : in_chan.brightness;
  end

  // ---------------------------------------------------------------- stage 2
  logic                s2_valid_r;
  sector_t             s2_sec_r;
  logic [VsW-1:0]      s2_vs_r, s2_vs_nxt;
  logic [FracW-1:0]    s2_val_r;
  logic [FracHueW-1:0] s2_xw_r, s2_xw_nxt;
  logic                s1_odd;

  // Chroma product v*s, and the weight of x: rising in even sectors,
  // falling in odd ones.
  always_comb begin
    s1_odd    = (s1_sec_r == SEC_Y_G) || (s1_sec_r == SEC_C_B) ||
                (s1_sec_r == SEC_M_R);
    s2_vs_nxt = VsW'(s1_val_r) * VsW'(s1_sat_r);
    s2_xw_nxt = s1_odd ? FracHueW'(HueSector) - s1_frac_r : s1_frac_r;
  end

  // ---------------------------------------------------------------- stage 3
  logic            s3_valid_r;
  sector_t         s3_sec_r;
  logic [NumW-1:0] s3_cn_r, s3_cn_nxt;
  logic [NumW-1:0] s3_xn_r, s3_xn_nxt;
  logic [NumW-1:0] s3_mn_r, s3_mn_nxt;
  logic [VsW-1:0]  s2_mv;

  // Chroma, x and the offset m, all over the denominator 65536*960.
  always_comb begin
    s2_mv     = {s2_val_r, 8'd0} - s2_vs_r;
    s3_cn_nxt = NumW'(s2_vs_r) * NumW'(HueSector);
    s3_xn_nxt = NumW'(s2_vs_r) * NumW'(s2_xw_r);
    s3_mn_nxt = NumW'(s2_mv) * NumW'(HueSector);
  end

  // ---------------------------------------------------------------- stage 4
  logic            s4_valid_r;
  logic [PreW-1:0] s4_r_r, s4_r_nxt;
  logic [PreW-1:0] s4_g_r, s4_g_nxt;
  logic [PreW-1:0] s4_b_r, s4_b_nxt;
  logic [NumW-1:0] rc, gc, bc;

  // Place c, x and zero on the channels by sector, add m and scale by 255.
  always_comb begin
    case (s3_sec_r)
      SEC_R_Y: begin rc = s3_cn_r; gc = s3_xn_r; bc = '0;      end
      SEC_Y_G: begin rc = s3_xn_r; gc = s3_cn_r; bc = '0;      end
      SEC_G_C: begin rc = '0;      gc = s3_cn_r; bc = s3_xn_r; end
      SEC_C_B: begin rc = '0;      gc = s3_xn_r; bc = s3_cn_r; end
      SEC_B_M: begin rc = s3_xn_r; gc = '0;      bc = s3_cn_r; end
      default: begin rc = s3_cn_r; gc = '0;      bc = s3_xn_r; end
    endcase
    s4_r_nxt = scale_255(rc + s3_mn_r);
    s4_g_nxt = scale_255(gc + s3_mn_r);
    s4_b_nxt = scale_255(bc + s3_mn_r);
  end

  // ---------------------------------------------------------------- stage 5
  logic             s5_valid_r;
  logic [ChanW-1:0] s5_r_r, s5_g_r, s5_b_r;

  assign out_chan.valid = s5_valid_r;
  assign out_chan.red   = s5_r_r;
  assign out_chan.green = s5_g_r;
  assign out_chan.blue  = s5_b_r;

  // Valid bits of all stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_chan.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  // Payload registers of all stages.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sec_r  <= s1_sec_nxt;
      s1_frac_r <= s1_frac_nxt;
      s1_sat_r  <= s1_sat_nxt;
      s1_val_r  <= s1_val_nxt;

      s2_sec_r  <= s1_sec_r;
      s2_vs_r   <= s2_vs_nxt;
      s2_val_r  <= s1_val_r;
      s2_xw_r   <= s2_xw_nxt;

      s3_sec_r  <= s2_sec_r;
      s3_cn_r   <= s3_cn_nxt;
      s3_xn_r   <= s3_xn_nxt;
      s3_mn_r   <= s3_mn_nxt;

      s4_r_r    <= s4_r_nxt;
      s4_g_r    <= s4_g_nxt;
      s4_b_r    <= s4_b_nxt;

      s5_r_r    <= div15_clamp(s4_r_r);
      s5_g_r    <= div15_clamp(s4_g_r);
      s5_b_r    <= div15_clamp(s4_b_r);
    end
  end

endmodule

`default_nettype wire
